// ===== hdl/shs_pkg.sv =====
// ---------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and functions of the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package shs_pkg;

   localparam int unsigned DigestWords = 8;
   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned SchedWords  = 16;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned LenBytes    = 8;

   localparam logic [7:0] PadMark      = 8'h80;
   localparam logic [5:0] LengthOffset = 6'd56;
   localparam logic [5:0] LastFill     = 6'd63;
   localparam logic [5:0] LastRound    = 6'd63;
   localparam logic [3:0] LenDone      = 4'd8;
   localparam logic [2:0] LastWord     = 3'd7;

   typedef logic [31:0]                  word_type;
   typedef logic [DigestWords-1:0][31:0] hash_type;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic init_work;   // copy hash words into working variables
      logic round_en;    // run one compression round
      logic add_en;      // fold working variables into hash words
      logic clr_hash;    // return hash words to initial values
   } round_ctrl_type;

   // Control from the sequencer to the schedule window.
   typedef struct packed {
      logic byte_en;     // shift one message byte into the window
      logic round_en;    // advance the window by one schedule word
      logic recirc;      // rounds 0..15: reuse loaded words
   } sched_ctrl_type;

   localparam hash_type InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic word_type ror32(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

endpackage

// ===== hdl/shs_sched.sv =====
// ---------------------------------------------------------------------------
// shs_sched
// Message schedule window: gathers bytes of a block, then yields W[t].
// ---------------------------------------------------------------------------
module shs_sched (
   input  logic                     clock,
   input  shs_pkg::sched_ctrl_type  ctrl,
   input  logic [7:0]               byte_data,
   output shs_pkg::word_type        sched_word
);

   // win_ff[0] is the oldest word (W[t-16]), win_ff[15] the newest.
   shs_pkg::word_type win_ff [shs_pkg::SchedWords];
   shs_pkg::word_type win_in [shs_pkg::SchedWords];
   shs_pkg::word_type expand_word;

   always_comb begin
      expand_word = win_ff[0] + shs_pkg::small_sigma0(win_ff[1]) + win_ff[9]
                  + shs_pkg::small_sigma1(win_ff[14]);
      sched_word  = ctrl.recirc ? win_ff[0] : expand_word;
   end

   always_comb begin
      for (int i = 0; i < shs_pkg::SchedWords; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.byte_en) begin
         // whole window acts as a 64-byte shift line, big-endian
         for (int i = 0; i < shs_pkg::SchedWords - 1; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[shs_pkg::SchedWords-1] = {win_ff[shs_pkg::SchedWords-1][23:0], byte_data};
      end else if (ctrl.round_en) begin
         for (int i = 0; i < shs_pkg::SchedWords - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[shs_pkg::SchedWords-1] = sched_word;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < shs_pkg::SchedWords; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

// ===== hdl/shs_round.sv =====
// ---------------------------------------------------------------------------
// shs_round
// Compression round unit and hash word store.
// ---------------------------------------------------------------------------
module shs_round (
   input  logic                     clock,
   input  logic                     reset,
   input  shs_pkg::round_ctrl_type  ctrl,
   input  shs_pkg::word_type        sched_word,
   input  logic [5:0]               round_idx,
   output shs_pkg::hash_type        hash_words
);

   shs_pkg::hash_type hash_ff, hash_in;
   shs_pkg::hash_type work_ff, work_in;
   shs_pkg::word_type t1, t2, choose, major;

   always_comb begin
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
      t1 = work_ff[7] + shs_pkg::big_sigma1(work_ff[4]) + choose
         + shs_pkg::round_k(round_idx) + sched_word;
      t2 = shs_pkg::big_sigma0(work_ff[0]) + major;

      work_in = work_ff;
      if (ctrl.init_work) begin
         work_in = hash_ff;
      end else if (ctrl.round_en) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end

      hash_in = hash_ff;
      if (ctrl.clr_hash) begin
         hash_in = shs_pkg::InitHash;
      end else if (ctrl.add_en) begin
         for (int i = 0; i < shs_pkg::DigestWords; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= shs_pkg::InitHash;
      end else begin
         hash_ff <= hash_in;
      end
      work_ff <= work_in;
   end

   assign hash_words = hash_ff;

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream; emits the digest as eight 32-bit words.
// ---------------------------------------------------------------------------
//
//   Channel | Ports                                        | Moves
//   --------+----------------------------------------------+-------------------
//   req     | req_valid/ready, data_byte, has_byte, end_.. | one message byte
//   rsp     | rsp_valid/ready, digest_word, word_index, .. | one digest word
//
// A byte is taken while req_valid and req_ready are high. The 64th byte of
// a block starts the compression rounds and then the hash update; the shared
// round unit runs one round per cycle. An end-of-message word adds the
// padding bytes (9..72) and one or two compressions, then eight digest
// words. req_ready is low while compressing, padding or emitting. A stalled
// rsp side holds the current digest word. Reset restores the initial hash
// values and clears the byte count.
// ---------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,     // taking message bytes
      ST_PAD,      // inserting padding and length bytes
      ST_ROUND,    // 64 compression rounds
      ST_ADD,      // fold working variables into hash
      ST_OUT       // emitting digest words
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;         // bytes held in the window
   logic [5:0]  round_ff, round_in;
   logic [63:0] total_ff, total_in;       // byte count; shifted out as length
   logic        pend_end_ff, pend_end_in; // message end seen, padding owed
   logic        mark_ff, mark_in;         // 0x80 already inserted
   logic [3:0]  len_ff, len_in;           // length bytes inserted
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        req_accept;
   logic        ins_en;
   logic [7:0]  ins_byte;
   logic        block_full;

   shs_pkg::round_ctrl_type round_ctrl;
   shs_pkg::sched_ctrl_type sched_ctrl;
   shs_pkg::word_type       sched_word;
   shs_pkg::hash_type       hash_words;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // Byte source for the window: the stream while idle, padding in ST_PAD.
   always_comb begin
      ins_en   = 1'b0;
      ins_byte = req_data_byte;
      case (state_ff)
         ST_IDLE: begin
            ins_en = req_accept && req_has_byte;
         end
         ST_PAD: begin
            ins_en = 1'b1;
            if (!mark_ff) begin
               ins_byte = shs_pkg::PadMark;
            end else if (len_ff == 4'd0 && fill_ff != shs_pkg::LengthOffset) begin
               ins_byte = 8'h00;
            end else begin
               // bit length = count * 8; its top byte is count[60:53]
               ins_byte = total_ff[60:53];
            end
         end
         default: begin
            ins_en = 1'b0;
         end
      endcase
   end

   assign block_full = ins_en && (fill_ff == shs_pkg::LastFill);

   always_comb begin
      state_in    = state_ff;
      fill_in     = ins_en ? fill_ff + 6'd1 : fill_ff;
      round_in    = round_ff;
      total_in    = total_ff;
      pend_end_in = pend_end_ff;
      mark_in     = mark_ff;
      len_in      = len_ff;
      out_idx_in  = out_idx_ff;

      round_ctrl  = '0;
      sched_ctrl  = '0;
      sched_ctrl.byte_en   = ins_en;
      round_ctrl.init_work = block_full;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pend_end_in = req_end_of_message;
               if (req_has_byte) begin
                  total_in = total_ff + 64'd1;
               end
               if (block_full) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (!mark_ff) begin
               mark_in = 1'b1;
            end else if (!(len_ff == 4'd0 && fill_ff != shs_pkg::LengthOffset)) begin
               len_in   = len_ff + 4'd1;
               total_in = {total_ff[55:0], 8'h00};
            end
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_ctrl.round_en = 1'b1;
            sched_ctrl.round_en = 1'b1;
            sched_ctrl.recirc   = (round_ff[5:4] == 2'b00);
            round_in = round_ff + 6'd1;
            if (round_ff == shs_pkg::LastRound) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            round_ctrl.add_en = 1'b1;
            if (len_ff == shs_pkg::LenDone) begin
               state_in = ST_OUT;
            end else if (pend_end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == shs_pkg::LastWord) begin
                  // back to a fresh message
                  round_ctrl.clr_hash = 1'b1;
                  total_in    = '0;
                  pend_end_in = 1'b0;
                  mark_in     = 1'b0;
                  len_in      = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         round_ff    <= '0;
         total_ff    <= '0;
         pend_end_ff <= 1'b0;
         mark_ff     <= 1'b0;
         len_ff      <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         round_ff    <= round_in;
         total_ff    <= total_in;
         pend_end_ff <= pend_end_in;
         mark_ff     <= mark_in;
         len_ff      <= len_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   shs_sched u_sched (
      .clock      (clock),
      .ctrl       (sched_ctrl),
      .byte_data  (ins_byte),
      .sched_word (sched_word)
   );

   shs_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (round_ctrl),
      .sched_word (sched_word),
      .round_idx  (round_ff),
      .hash_words (hash_words)
   );

   // Digest words come straight from the hash registers, stable while stalled.
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_words[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == shs_pkg::LastWord);

endmodule

// ===== sim/sha256_stream_hasher_tb.sv =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking bench for the SHA-256 stream hasher.
// A short table of directed words comes first: the empty message, ignored
// words, a byte riding on the end marker, and byte extremes. Random messages
// follow, often with lengths around the padding boundaries. Every digest word
// is checked in order against a local SHA-256 model or the typed-in empty
// message digest, and both channels see random idle gaps.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_stream_hasher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // SHA-256 constants (FIPS 180-4)
   // ------------------------------------------------------------------
   localparam logic [31:0] IvWords [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenAt   = 6'd56;   // bit length starts here

   // Well-known digest of the zero-length message.
   localparam logic [255:0] EmptyDigest =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;

   localparam int RandomItems = 380;
   localparam int TailCycles  = 300;   // > worst padding + two compressions

   // ------------------------------------------------------------------
   // Directed table. known = 1 means the digest is the typed-in empty
   // message digest; all other rows go through the local model.
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       eom;
      bit         known;
   } stim_row_type;

   localparam int DirRows = 15;
   localparam stim_row_type DirTable [DirRows] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1},   // end with no byte straight after reset
      '{8'hff, 1'b0, 1'b0, 1'b0},   // neither byte nor end: ignored
      '{8'h00, 1'b1, 1'b1, 1'b0},   // single byte on the end word
      '{8'h00, 1'b0, 1'b1, 1'b1},   // empty again: state went back to IV
      '{8'hff, 1'b1, 1'b0, 1'b0},
      '{8'h61, 1'b1, 1'b0, 1'b0},
      '{8'h62, 1'b1, 1'b0, 1'b0},
      '{8'h63, 1'b1, 1'b0, 1'b0},
      '{8'h5a, 1'b0, 1'b0, 1'b0},   // stray data mid-message, not absorbed
      '{8'hff, 1'b0, 1'b1, 1'b0},   // end without byte, data must be ignored
      '{8'hff, 1'b1, 1'b1, 1'b0},   // one-byte message of all ones
      '{8'h80, 1'b1, 1'b0, 1'b0},
      '{8'h7f, 1'b1, 1'b0, 1'b0},
      '{8'h01, 1'b1, 1'b0, 1'b0},
      '{8'hfe, 1'b1, 1'b1, 1'b0}
   };

   // ------------------------------------------------------------------
   // Local hash model state
   // ------------------------------------------------------------------
   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   logic [5:0]  fill_idx;
   logic [63:0] msg_bytes;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_word_type;

   digest_word_type digest_words_due [$];
   int              mismatches;
   bit              quiet;   // no sender gaps for the current message

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
      fill_idx  = '0;
      msg_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                 block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + RoundK[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      block_bytes[fill_idx] = b;
      fill_idx = fill_idx + 6'd1;
      if (fill_idx == 6'd0) compress_block();
   endfunction

   // Feed one accepted word to the model; returns 1 with the digest when the
   // word ends a message.
   function automatic bit hash_word(input logic [7:0] b, input logic hb,
                                    input logic eom, output logic [255:0] dig);
      logic [63:0] bit_len;
      dig = '0;
      if (hb) begin
         msg_bytes = msg_bytes + 64'd1;
         absorb_byte(b);
      end
      if (!eom) return 1'b0;
      bit_len = msg_bytes << 3;
      absorb_byte(PadByte);
      while (fill_idx != LenAt) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = hash_state[i];
      restart_hash();
      return 1'b1;
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Sender: offer one word, wait for it to be taken, update the model.
   // Returns in the acceptance step when no gap follows, so the next call
   // replaces the payload without dropping valid.
   // ------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b, input logic hb, input logic eom,
                            input bit known);
      logic [255:0]    dig;
      digest_word_type dw;
      int              gap;
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_has_byte       <= hb;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      if (hash_word(b, hb, eom, dig)) begin
         if (known) dig = EmptyDigest;
         for (int i = 0; i < 8; i++) begin
            dw.word = dig[255-32*i -: 32];
            dw.idx  = 3'(i);
            dw.last = (i == 7);
            digest_words_due = {digest_words_due, dw};
         end
      end
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the input side until every digest word owed has come back.
   task automatic drain_digests();
      req_valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clock);
   endtask

   // Message length: often near the 56/64-byte padding edges.
   function automatic int pick_length();
      int edges [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 8)];
      return $urandom_range(0, 40);
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random ready pattern, check each accepted digest word.
   // ------------------------------------------------------------------
   initial begin
      int              hold;
      int              gap;
      digest_word_type dw;
      rsp_ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (digest_words_due.size() == 0) begin
               flag_mismatch("digest word with none pending", rsp_digest_word, '0);
            end else begin
               dw = digest_words_due.pop_front();
               if (rsp_digest_word !== dw.word)
                  flag_mismatch("digest_word", rsp_digest_word, dw.word);
               if (rsp_word_index !== dw.idx)
                  flag_mismatch("word_index", 32'(rsp_word_index), 32'(dw.idx));
               if (rsp_last_word !== dw.last)
                  flag_mismatch("last_word", 32'(rsp_last_word), 32'(dw.last));
            end
         end
         // ready pattern: stretches of ready, stalls of random length
         if (hold > 0) begin
            hold--;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(0, 20);
            end else begin
               rsp_ready <= 1'b0;
               hold = gap - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int   items;
      int   len;
      bit   ride;
      bit   paused;
      stim_row_type row;
      mismatches = 0;
      items      = 0;
      paused     = 0;
      quiet      = 0;
      restart_hash();
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_data_byte      <= 8'h00;
      req_has_byte       <= 1'b0;
      req_end_of_message <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DirRows; r++) begin
         row = DirTable[r];
         send_word(row.data, row.has, row.eom, row.known);
      end

      // random messages; noise words sprinkled in count as items too
      while (items < RandomItems) begin
         len   = pick_length();
         ride  = (len > 0) && ($urandom_range(0, 1) == 1);
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
               items++;
            end
            send_word(8'($urandom_range(0, 255)), 1'b1,
                      (ride && k == len - 1), 1'b0);
            items++;
         end
         if (!ride) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
            items++;
         end
         // once, mid-run, let the output side empty completely
         if (!paused && items >= RandomItems / 2) begin
            paused = 1;
            drain_digests();
            @(posedge clock);
         end
      end

      drain_digests();
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/shs_pkg.sv
hdl/shs_sched.sv
hdl/shs_round.sv
hdl/sha256_stream_hasher.sv
sim/sha256_stream_hasher_tb.sv
